// ===== rtl/core/lifo_stack_fill_level_assert.svh =====
// Assertion macros used by the stack top level
`ifndef LIFO_STACK_FILL_LEVEL_ASSERT_SVH
`define LIFO_STACK_FILL_LEVEL_ASSERT_SVH

// same-cycle implication, clocked on clk_i, idle in reset
`define LSFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, idle in reset
`define LSFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lsfl_pkg.sv =====
// Types, codes and helpers of the LIFO stack with fill level
`default_nettype none
package lsfl_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned CntW         = 5;
  localparam logic [CntW-1:0] CapReset = 5'd16;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  cls;
    logic [31:0] tim;
  } entry_t;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_LIST = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    LVL_NONE      = 3'd0,
    LVL_LOW       = 3'd1,
    LVL_MEDIUM    = 3'd2,
    LVL_HIGH      = 3'd3,
    LVL_CONGESTED = 3'd4
  } level_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD_DN = 2'd1,
    CELL_LOAD_UP = 2'd2
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_e;

  // floor(x/3) for x below 64: multiply by 43/128
  function automatic logic [CntW-1:0] div3_f(input logic [5:0] x);
    logic [11:0] p;
    p = 12'(x) * 12'd43;
    return p[11:7];
  endfunction

  function automatic level_e fill_level_f(input logic [CntW-1:0] n,
                                          input logic [CntW-1:0] cap);
    logic [CntW-1:0] t1;
    logic [CntW-1:0] t2;
    level_e          lvl;
    t1 = div3_f({1'b0, cap});
    t2 = div3_f({cap, 1'b0});
    if (n == '0) begin
      lvl = LVL_NONE;
    end else if (n <= t1) begin
      lvl = LVL_LOW;
    end else if (n <= t2) begin
      lvl = LVL_MEDIUM;
    end else if (n < cap) begin
      lvl = LVL_HIGH;
    end else begin
      lvl = LVL_CONGESTED;
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsfl_req_if.sv =====
// Request channel: valid/ready with the request payload
`default_nettype none
interface lsfl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] vehicle_id;
  logic [7:0]  vehicle_class;
  logic [31:0] timestamp;

  modport source (output valid, req_type, vehicle_id, vehicle_class, timestamp,
                  input ready);
  modport sink   (input valid, req_type, vehicle_id, vehicle_class, timestamp,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lsfl_rsp_if.sv =====
// Response channel: valid/ready with the result payload
`default_nettype none
interface lsfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [7:0]  out_class;
  logic [31:0] out_time;
  logic [4:0]  occupancy;
  logic [2:0]  fill_level;
  logic        last;

  modport source (output valid, status, out_id, out_class, out_time, occupancy,
                  fill_level, last, input ready);
  modport sink   (input valid, status, out_id, out_class, out_time, occupancy,
                  fill_level, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lsfl_cell.sv =====
// One stack cell: holds an entry, loads from either neighbour
`default_nettype none
module lsfl_cell
  import lsfl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire cell_op_e op_i,
  input  wire entry_t   upper_i,
  input  wire entry_t   lower_i,
  output entry_t        q_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_LOAD_DN: entry_q <= upper_i;
      CELL_LOAD_UP: entry_q <= lower_i;
      default:      entry_q <= entry_q;
    endcase
  end

  assign q_o = entry_q;

endmodule
`default_nettype wire

// ===== rtl/core/lsfl_chain.sv =====
// Row of stack cells, top at cell 0, with bottom-entry select
`default_nettype none
module lsfl_chain
  import lsfl_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic            clk_i,
  input  wire cell_op_e        op_i,
  input  wire entry_t          ins_i,
  input  wire logic [CntW-1:0] count_i,
  output entry_t               top_o,
  output entry_t               bottom_o
);

  entry_t cell_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t upper;
    entry_t lower;
    if (g == 0) begin : g_head
      assign upper = ins_i;
    end else begin : g_body
      assign upper = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign lower = cell_q[g];
    end else begin : g_mid
      assign lower = cell_q[g+1];
    end
    lsfl_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .upper_i (upper),
      .lower_i (lower),
      .q_o     (cell_q[g])
    );
  end

  // one-hot pick of the deepest held entry
  always_comb begin
    bottom_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(count_i) == i + 1) begin
        bottom_o = bottom_o | cell_q[i];
      end
    end
  end

  assign top_o = cell_q[0];

endmodule
`default_nettype wire

// ===== rtl/core/lifo_stack_fill_level.sv =====
// Top level of the LIFO stack with fill level
// Push, pop and peek: the registered result beat follows in the cycle after the accepted beat.
// List of n entries: after the accept, one result beat per cycle unless stalled,
// paced by the rotation of the cell chain; no new request is taken meanwhile.
// A single-result request may follow every cycle while the output is drained.
// Reset: asynchronous, clears occupancy, state and output valid; capacity to 16.
`default_nettype none
`include "lifo_stack_fill_level_assert.svh"
module lifo_stack_fill_level
  import lsfl_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  lsfl_req_if.sink             req_i,
  lsfl_rsp_if.source           rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CntW-1:0] cfg_wdata_i
);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cap_q;
  logic [CntW-1:0] cap_eff;
  logic            out_valid_q;
  status_e         out_status_q, out_status_d;
  entry_t          out_entry_q, out_entry_d;
  logic [CntW-1:0] out_occ_q;
  level_e          out_level_q;
  logic            out_last_q, out_last_d;
  logic            load_out;
  logic            out_free;
  logic            in_acc;
  logic            list_step;
  cell_op_e        cell_op;
  entry_t          ins;
  entry_t          top_entry;
  entry_t          bottom_entry;
  entry_t          req_entry;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (int'(cap_q) > int'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc      = req_i.valid && req_i.ready;
  assign list_step   = (state_q == S_LIST) && out_free;

  assign req_entry.id  = req_i.vehicle_id;
  assign req_entry.cls = req_i.vehicle_class;
  assign req_entry.tim = req_i.timestamp;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    cell_op      = CELL_HOLD;
    ins          = req_entry;
    load_out     = 1'b0;
    out_status_d = STAT_OK;
    out_entry_d  = '0;
    out_last_d   = 1'b1;
    if (in_acc) begin
      case (req_e'(req_i.req_type))
        REQ_PUSH: begin
          load_out = 1'b1;
          if (count_q >= cap_eff) begin
            out_status_d = STAT_FULL;
          end else begin
            cell_op = CELL_LOAD_DN;
            count_d = count_q + CntW'(1);
          end
        end
        REQ_POP: begin
          load_out = 1'b1;
          if (count_q == '0) begin
            out_status_d = STAT_EMPTY;
          end else begin
            cell_op     = CELL_LOAD_UP;
            count_d     = count_q - CntW'(1);
            out_entry_d = top_entry;
          end
        end
        REQ_PEEK: begin
          load_out = 1'b1;
          if (count_q == '0) begin
            out_status_d = STAT_EMPTY;
          end else begin
            out_entry_d = top_entry;
          end
        end
        default: begin
          if (count_q == '0) begin
            load_out     = 1'b1;
            out_status_d = STAT_EMPTY;
          end else begin
            state_d = S_LIST;
            rem_d   = count_q;
          end
        end
      endcase
    end else if (list_step) begin
      // rotate the bottom entry to the top and send it
      cell_op     = CELL_LOAD_DN;
      ins         = bottom_entry;
      load_out    = 1'b1;
      out_entry_d = bottom_entry;
      out_last_d  = (rem_q == CntW'(1));
      rem_d       = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        state_d = S_IDLE;
      end
    end
  end

  lsfl_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i    (clk_i),
    .op_i     (cell_op),
    .ins_i    (ins),
    .count_i  (count_q),
    .top_o    (top_entry),
    .bottom_o (bottom_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_occ_q    <= count_d;
      out_level_q  <= fill_level_f(count_d, cap_eff);
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.out_id     = out_entry_q.id;
  assign rsp_o.out_class  = out_entry_q.cls;
  assign rsp_o.out_time   = out_entry_q.tim;
  assign rsp_o.occupancy  = out_occ_q;
  assign rsp_o.fill_level = out_level_q;
  assign rsp_o.last       = out_last_q;

  `LSFL_ASSERT_NEXT(a_full_push_holds,
    in_acc && (req_i.req_type == REQ_PUSH) && (count_q >= cap_eff),
    $stable(count_q), "full push changed occupancy")
  `LSFL_ASSERT_NEXT(a_accept_yields_work, in_acc,
    (state_q == S_LIST) || out_valid_q, "accepted beat produced nothing")
  `LSFL_ASSERT_NEXT(a_list_ends, list_step && (rem_q == CntW'(1)),
    (state_q == S_IDLE) && out_valid_q && out_last_q, "list did not close")
  `LSFL_ASSERT_NOW(a_list_count_stable, state_q == S_LIST,
    (rem_q != '0) && (rem_q <= count_q), "list counter out of range")

endmodule
`default_nettype wire
